// ----- rtl/rtc_ts_pkg.sv -----
`default_nettype none

package rtc_ts_pkg;

   localparam int unsigned ActionWidth = 3;
   localparam int unsigned HalfWidth   = 15;
   localparam int unsigned CountWidth  = 16;
   localparam int unsigned AddrWidth   = 3;
   localparam int unsigned DataWidth   = 32;

   localparam logic [ActionWidth-1:0] ACT_TICK      = 3'd0;
   localparam logic [ActionWidth-1:0] ACT_SELECT    = 3'd1;
   localparam logic [ActionWidth-1:0] ACT_INCREMENT = 3'd2;
   localparam logic [ActionWidth-1:0] ACT_SAVE      = 3'd3;
   localparam logic [ActionWidth-1:0] ACT_CANCEL    = 3'd4;
   localparam logic [ActionWidth-1:0] ACT_ENTER     = 3'd5;

   localparam logic [1:0] FIELD_SECONDS = 2'd0;
   localparam logic [1:0] FIELD_MINUTES = 2'd1;
   localparam logic [1:0] FIELD_HOURS   = 2'd2;

   localparam logic [0:0] REG_BLINK_HALF = 1'b0;

   localparam logic [HalfWidth-1:0] BLINK_HALF_RESET = 15'd200;
   localparam logic [5:0] MINSEC_LIMIT = 6'd60;
   localparam logic [4:0] HOUR_LIMIT   = 5'd24;

   typedef struct packed {
      logic [ActionWidth-1:0] action;
      logic [7:0]             hours_reg;
      logic [7:0]             minutes_reg;
      logic [7:0]             seconds_reg;
   } req_payload_type;

   typedef struct packed {
      logic [4:0] shown_hours;
      logic       hours_blank;
      logic [5:0] shown_minutes;
      logic       minutes_blank;
      logic [5:0] shown_seconds;
      logic       seconds_blank;
      logic [1:0] edited_field;
      logic       commit;
      logic       exit_menu;
      logic [5:0] hours_bcd;
      logic [6:0] minutes_bcd;
      logic [6:0] seconds_bcd;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ----- rtl/rtc_time_set_controller.sv -----
`default_nettype none

// Time-setting controller for a BCD real-time clock, driven by keypad actions and display
// ticks. Each accepted beat gives exactly one result beat. A beat is taken into an input
// register; when the result register is free or being taken, one pass of short logic
// updates the editing state and loads the result register, so one beat per cycle is
// sustained while the output does not stall. The input register can still take one beat
// while a finished result waits on a stalled output. blink_half_period (byte address 0,
// resets to 200) sets the blink: the edited field and its neighbour are shown after that
// many non-exit beats, the edited one blanked at twice that; write it only while idle.
module rtc_time_set_controller (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire rtc_ts_pkg::req_payload_type          req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output rtc_ts_pkg::rsp_payload_type               rsp_data,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [rtc_ts_pkg::AddrWidth-1:0]     csr_paddr,
   input  wire logic [rtc_ts_pkg::DataWidth-1:0]     csr_pwdata,
   output logic [rtc_ts_pkg::DataWidth-1:0]          csr_prdata,
   output logic                                      csr_pready
);

   logic [rtc_ts_pkg::HalfWidth-1:0]  half_ff;
   logic                              in_valid_ff;
   rtc_ts_pkg::req_payload_type       in_ff;
   logic                              out_valid_ff;
   rtc_ts_pkg::rsp_payload_type       out_ff;
   rtc_ts_pkg::rsp_payload_type       out_in;

   logic [4:0]                        hour_ff, hour_in;
   logic [5:0]                        minute_ff, minute_in;
   logic [5:0]                        second_ff, second_in;
   logic [1:0]                        field_ff, field_in;
   logic [rtc_ts_pkg::CountWidth-1:0] count_ff, count_in;
   logic                              loaded_ff, loaded_in;
   logic [4:0]                        shown_h_ff, shown_h_in;
   logic [5:0]                        shown_m_ff, shown_m_in;
   logic [5:0]                        shown_s_ff, shown_s_in;
   logic [2:0]                        blank_ff, blank_in;

   logic                              advance;
   logic                              csr_write;
   logic [rtc_ts_pkg::CountWidth-1:0] count_inc;
   logic [5:0]                        load_h;
   logic [7:0]                        load_m;
   logic [6:0]                        load_s;

   // binary to bcd for values below 64: tens by a row of threshold compares
   function automatic logic [7:0] to_bcd(input logic [5:0] v);
      logic [2:0] tens;
      logic [5:0] ones;
      tens = 3'd0;
      for (int k = 1; k <= 6; k++) begin
         if (v >= 6'(10 * k)) tens = 3'(k);
      end
      ones = v - 6'({tens, 3'b000} + {2'b00, tens, 1'b0});
      to_bcd = {1'b0, tens, ones[3:0]};
   endfunction

   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == rtc_ts_pkg::REG_BLINK_HALF);

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == rtc_ts_pkg::REG_BLINK_HALF) begin
         csr_prdata = {{(rtc_ts_pkg::DataWidth - rtc_ts_pkg::HalfWidth){1'b0}}, half_ff};
      end
   end

   // tens times ten as shift and add
   assign load_h = {1'b0, in_ff.hours_reg[5:4], 3'b000} + {3'b000, in_ff.hours_reg[5:4], 1'b0}
                   + {2'b00, in_ff.hours_reg[3:0]};
   assign load_m = {1'b0, in_ff.minutes_reg[7:4], 3'b000}
                   + {3'b000, in_ff.minutes_reg[7:4], 1'b0}
                   + {4'b0000, in_ff.minutes_reg[3:0]};
   assign load_s = {1'b0, in_ff.seconds_reg[6:4], 3'b000}
                   + {3'b000, in_ff.seconds_reg[6:4], 1'b0}
                   + {3'b000, in_ff.seconds_reg[3:0]};

   assign count_inc = count_ff + 1'b1;

   always_comb begin
      logic [7:0] bcd_h, bcd_m, bcd_s;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      field_in   = field_ff;
      count_in   = count_ff;
      loaded_in  = loaded_ff;
      shown_h_in = shown_h_ff;
      shown_m_in = shown_m_ff;
      shown_s_in = shown_s_ff;
      blank_in   = blank_ff;
      out_in     = '0;
      bcd_h      = to_bcd({1'b0, hour_ff});
      bcd_m      = to_bcd(minute_ff);
      bcd_s      = to_bcd(second_ff);

      if (in_ff.action == rtc_ts_pkg::ACT_SAVE || in_ff.action == rtc_ts_pkg::ACT_CANCEL) begin
         if (in_ff.action == rtc_ts_pkg::ACT_SAVE) begin
            out_in.commit      = 1'b1;
            out_in.hours_bcd   = bcd_h[5:0];
            out_in.minutes_bcd = bcd_m[6:0];
            out_in.seconds_bcd = bcd_s[6:0];
         end
         out_in.exit_menu = 1'b1;
         field_in  = rtc_ts_pkg::FIELD_SECONDS;
         loaded_in = 1'b0;
         count_in  = '0;
      end else begin
         if (in_ff.action == rtc_ts_pkg::ACT_ENTER && !loaded_ff) begin
            hour_in    = (load_h < 6'(rtc_ts_pkg::HOUR_LIMIT)) ? load_h[4:0] : 5'd0;
            minute_in  = (load_m < 8'(rtc_ts_pkg::MINSEC_LIMIT)) ? load_m[5:0] : 6'd0;
            second_in  = (load_s < 7'(rtc_ts_pkg::MINSEC_LIMIT)) ? load_s[5:0] : 6'd0;
            loaded_in  = 1'b1;
            shown_h_in = hour_in;
            shown_m_in = minute_in;
            shown_s_in = second_in;
            blank_in   = 3'b000;
         end else if (in_ff.action == rtc_ts_pkg::ACT_SELECT) begin
            field_in = (field_ff >= rtc_ts_pkg::FIELD_HOURS) ? rtc_ts_pkg::FIELD_SECONDS
                                                              : field_ff + 1'b1;
         end else if (in_ff.action == rtc_ts_pkg::ACT_INCREMENT) begin
            case (field_ff)
               rtc_ts_pkg::FIELD_SECONDS: begin
                  second_in = (second_ff + 1'b1 >= rtc_ts_pkg::MINSEC_LIMIT) ? 6'd0
                                                                              : second_ff + 1'b1;
               end
               rtc_ts_pkg::FIELD_MINUTES: begin
                  minute_in = (minute_ff + 1'b1 >= rtc_ts_pkg::MINSEC_LIMIT) ? 6'd0
                                                                              : minute_ff + 1'b1;
               end
               rtc_ts_pkg::FIELD_HOURS: begin
                  hour_in = (hour_ff + 1'b1 >= rtc_ts_pkg::HOUR_LIMIT) ? 5'd0 : hour_ff + 1'b1;
               end
               default: begin
               end
            endcase
         end

         // blink step, acting on the values just updated
         count_in = count_inc;
         if (count_inc == {1'b0, half_ff}) begin
            case (field_in)
               rtc_ts_pkg::FIELD_SECONDS, rtc_ts_pkg::FIELD_MINUTES: begin
                  shown_s_in  = second_in;
                  shown_m_in  = minute_in;
                  blank_in[0] = 1'b0;
                  blank_in[1] = 1'b0;
               end
               rtc_ts_pkg::FIELD_HOURS: begin
                  shown_h_in  = hour_in;
                  shown_m_in  = minute_in;
                  blank_in[2] = 1'b0;
                  blank_in[1] = 1'b0;
               end
               default: begin
               end
            endcase
         end else if (count_inc == {half_ff, 1'b0}) begin
            count_in = '0;
            case (field_in)
               rtc_ts_pkg::FIELD_SECONDS: blank_in[0] = 1'b1;
               rtc_ts_pkg::FIELD_MINUTES: blank_in[1] = 1'b1;
               rtc_ts_pkg::FIELD_HOURS:   blank_in[2] = 1'b1;
               default: begin
               end
            endcase
         end
      end

      out_in.shown_hours   = shown_h_in;
      out_in.hours_blank   = blank_in[2];
      out_in.shown_minutes = shown_m_in;
      out_in.minutes_blank = blank_in[1];
      out_in.shown_seconds = shown_s_in;
      out_in.seconds_blank = blank_in[0];
      out_in.edited_field  = field_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff      <= rtc_ts_pkg::BLINK_HALF_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         field_ff     <= '0;
         count_ff     <= '0;
         loaded_ff    <= 1'b0;
         shown_h_ff   <= '0;
         shown_m_ff   <= '0;
         shown_s_ff   <= '0;
         blank_ff     <= '0;
      end else begin
         if (csr_write) begin
            half_ff <= csr_pwdata[rtc_ts_pkg::HalfWidth-1:0];
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            hour_ff    <= hour_in;
            minute_ff  <= minute_in;
            second_ff  <= second_in;
            field_ff   <= field_in;
            count_ff   <= count_in;
            loaded_ff  <= loaded_in;
            shown_h_ff <= shown_h_in;
            shown_m_ff <= shown_m_in;
            shown_s_ff <= shown_s_in;
            blank_ff   <= blank_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/rtc_ts_checker.sv -----
`default_nettype none

module rtc_ts_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire rtc_ts_pkg::rsp_payload_type rsp_data
);

   // a commit always leaves the menu
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.commit |-> rsp_data.exit_menu)
      else $error("commit without exit_menu");

   // bcd digits are driven only with a commit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.commit |->
         rsp_data.hours_bcd == 6'd0 && rsp_data.minutes_bcd == 7'd0
         && rsp_data.seconds_bcd == 7'd0)
      else $error("bcd digits without commit");

   // leaving the menu resets the edited field to seconds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.exit_menu |-> rsp_data.edited_field == rtc_ts_pkg::FIELD_SECONDS)
      else $error("edited field not cleared on exit");

   // the shown hour never leaves the day
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.shown_hours < rtc_ts_pkg::HOUR_LIMIT)
      else $error("shown hour out of range");

   // nothing offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind rtc_time_set_controller rtc_ts_checker u_rtc_ts_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- dv/tb_rtc_time_set_controller.sv -----
`default_nettype none

module tb_rtc_time_set_controller;

   localparam logic [rtc_ts_pkg::ActionWidth-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [rtc_ts_pkg::ActionWidth-1:0] ACT_SPARE_HI = 3'd7;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned HOLD_CYCLES    = 40;
   localparam int unsigned SETTLE_CYCLES  = 8;

   // tracks the editing state and keeps the results the block owes us
   class time_set_tracker;
      rtc_ts_pkg::rsp_payload_type          expected_results[$];
      logic [4:0]                           hour_val;
      logic [5:0]                           minute_val;
      logic [5:0]                           second_val;
      logic [1:0]                           field_sel;
      logic [rtc_ts_pkg::CountWidth-1:0]    blink_cnt;
      logic                                 is_loaded;
      logic [16:0]                          shown;
      logic [2:0]                           blanked;
      logic [rtc_ts_pkg::HalfWidth-1:0]     blink_half;
      int unsigned                          failures;

      function new();
         hour_val   = '0;
         minute_val = '0;
         second_val = '0;
         field_sel  = rtc_ts_pkg::FIELD_SECONDS;
         blink_cnt  = '0;
         is_loaded  = 1'b0;
         shown      = '0;
         blanked    = '0;
         blink_half = rtc_ts_pkg::BLINK_HALF_RESET;
         failures   = 0;
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction

      function int bcd_of(int v);
         return ((v / 10) << 4) | (v % 10);
      endfunction

      function void advance_blink();
         blink_cnt = blink_cnt + 16'd1;
         if (blink_cnt == {1'b0, blink_half}) begin
            case (field_sel)
               rtc_ts_pkg::FIELD_SECONDS, rtc_ts_pkg::FIELD_MINUTES: begin
                  shown[11:6] = minute_val;
                  shown[5:0]  = second_val;
                  blanked[1:0] = 2'b00;
               end
               rtc_ts_pkg::FIELD_HOURS: begin
                  shown[16:12] = hour_val;
                  shown[11:6]  = minute_val;
                  blanked[2:1] = 2'b00;
               end
               default: ;
            endcase
         end else if (blink_cnt == {blink_half, 1'b0}) begin
            blink_cnt = '0;
            case (field_sel)
               rtc_ts_pkg::FIELD_SECONDS: blanked[0] = 1'b1;
               rtc_ts_pkg::FIELD_MINUTES: blanked[1] = 1'b1;
               rtc_ts_pkg::FIELD_HOURS:   blanked[2] = 1'b1;
               default: ;
            endcase
         end
      endfunction

      function void note_request(rtc_ts_pkg::req_payload_type item);
         rtc_ts_pkg::rsp_payload_type want;
         int h;
         int m;
         int s;
         want = '0;
         if (item.action == rtc_ts_pkg::ACT_SAVE || item.action == rtc_ts_pkg::ACT_CANCEL) begin
            if (item.action == rtc_ts_pkg::ACT_SAVE) begin
               want.commit      = 1'b1;
               want.hours_bcd   = 6'(bcd_of(int'(hour_val)));
               want.minutes_bcd = 7'(bcd_of(int'(minute_val)));
               want.seconds_bcd = 7'(bcd_of(int'(second_val)));
            end
            want.exit_menu = 1'b1;
            field_sel = rtc_ts_pkg::FIELD_SECONDS;
            is_loaded = 1'b0;
            blink_cnt = '0;
         end else begin
            if (item.action == rtc_ts_pkg::ACT_ENTER && !is_loaded) begin
               // hour tens keep 2 bits, second tens 3, minute tens all 4
               h = 10 * int'(item.hours_reg[5:4]) + int'(item.hours_reg[3:0]);
               m = 10 * int'(item.minutes_reg[7:4]) + int'(item.minutes_reg[3:0]);
               s = 10 * int'(item.seconds_reg[6:4]) + int'(item.seconds_reg[3:0]);
               hour_val   = (h < int'(rtc_ts_pkg::HOUR_LIMIT)) ? 5'(h) : '0;
               minute_val = (m < int'(rtc_ts_pkg::MINSEC_LIMIT)) ? 6'(m) : '0;
               second_val = (s < int'(rtc_ts_pkg::MINSEC_LIMIT)) ? 6'(s) : '0;
               is_loaded  = 1'b1;
               shown      = {hour_val, minute_val, second_val};
               blanked    = '0;
            end else if (item.action == rtc_ts_pkg::ACT_SELECT) begin
               field_sel = (field_sel >= rtc_ts_pkg::FIELD_HOURS) ? rtc_ts_pkg::FIELD_SECONDS
                                                                   : field_sel + 2'd1;
            end else if (item.action == rtc_ts_pkg::ACT_INCREMENT) begin
               case (field_sel)
                  rtc_ts_pkg::FIELD_SECONDS:
                     second_val = (second_val == rtc_ts_pkg::MINSEC_LIMIT - 6'd1) ?
                                  '0 : second_val + 6'd1;
                  rtc_ts_pkg::FIELD_MINUTES:
                     minute_val = (minute_val == rtc_ts_pkg::MINSEC_LIMIT - 6'd1) ?
                                  '0 : minute_val + 6'd1;
                  rtc_ts_pkg::FIELD_HOURS:
                     hour_val = (hour_val == rtc_ts_pkg::HOUR_LIMIT - 5'd1) ?
                                '0 : hour_val + 5'd1;
                  default: ;
               endcase
            end
            advance_blink();
         end
         want.shown_hours   = shown[16:12];
         want.shown_minutes = shown[11:6];
         want.shown_seconds = shown[5:0];
         want.hours_blank   = blanked[2];
         want.minutes_blank = blanked[1];
         want.seconds_blank = blanked[0];
         want.edited_field  = field_sel;
         expected_results.push_back(want);
      endfunction

      function void check_result(rtc_ts_pkg::rsp_payload_type got);
         rtc_ts_pkg::rsp_payload_type want;
         string bad;
         if (expected_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result beat %h", got);
            return;
         end
         want = expected_results.pop_front();
         bad = "";
         if (got.shown_hours   !== want.shown_hours)   bad = {bad, " shown_hours"};
         if (got.hours_blank   !== want.hours_blank)   bad = {bad, " hours_blank"};
         if (got.shown_minutes !== want.shown_minutes) bad = {bad, " shown_minutes"};
         if (got.minutes_blank !== want.minutes_blank) bad = {bad, " minutes_blank"};
         if (got.shown_seconds !== want.shown_seconds) bad = {bad, " shown_seconds"};
         if (got.seconds_blank !== want.seconds_blank) bad = {bad, " seconds_blank"};
         if (got.edited_field  !== want.edited_field)  bad = {bad, " edited_field"};
         if (got.commit        !== want.commit)        bad = {bad, " commit"};
         if (got.exit_menu     !== want.exit_menu)     bad = {bad, " exit_menu"};
         if (got.hours_bcd     !== want.hours_bcd)     bad = {bad, " hours_bcd"};
         if (got.minutes_bcd   !== want.minutes_bcd)   bad = {bad, " minutes_bcd"};
         if (got.seconds_bcd   !== want.seconds_bcd)   bad = {bad, " seconds_bcd"};
         if (bad != "") begin
            failures++;
            if (failures <= 10)
               $display("result mismatch on%s: expected %h got %h", bad, want, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rtc_ts_pkg::req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rtc_ts_pkg::rsp_payload_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [rtc_ts_pkg::AddrWidth-1:0] csr_paddr = '0;
   logic [rtc_ts_pkg::DataWidth-1:0] csr_pwdata = '0;
   logic [rtc_ts_pkg::DataWidth-1:0] csr_prdata;
   logic csr_pready;

   time_set_tracker tracker;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_left = 0;
   bit          start_hold = 1'b0;
   int unsigned quiet_cycles = 0;

   rtc_time_set_controller u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // receiver side: random stalls, plus one long hold-off when asked
   always @(negedge clock) begin
      if (start_hold) begin
         hold_left = HOLD_CYCLES;
         start_hold = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            tracker.check_result(rsp_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[rtc_time_set_controller] ERROR");
            $finish;
         end
      end
   end

   function automatic rtc_ts_pkg::req_payload_type key_beat(
         logic [rtc_ts_pkg::ActionWidth-1:0] action,
         logic [7:0] h, logic [7:0] m, logic [7:0] s);
      rtc_ts_pkg::req_payload_type item;
      item.action      = action;
      item.hours_reg   = h;
      item.minutes_reg = m;
      item.seconds_reg = s;
      return item;
   endfunction

   // mostly plausible bcd bytes, sometimes anything at all
   function automatic logic [7:0] clock_byte(int unsigned max_tens);
      if ($urandom_range(0, 3) == 0)
         return 8'($urandom_range(0, 255));
      return {4'($urandom_range(0, max_tens)), 4'($urandom_range(0, 9))};
   endfunction

   function automatic rtc_ts_pkg::req_payload_type random_beat();
      int unsigned r;
      logic [rtc_ts_pkg::ActionWidth-1:0] action;
      r = $urandom_range(0, 99);
      if (r < 35)      action = rtc_ts_pkg::ACT_TICK;
      else if (r < 38) action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      else if (r < 53) action = rtc_ts_pkg::ACT_SELECT;
      else if (r < 76) action = rtc_ts_pkg::ACT_INCREMENT;
      else if (r < 81) action = rtc_ts_pkg::ACT_SAVE;
      else if (r < 85) action = rtc_ts_pkg::ACT_CANCEL;
      else             action = rtc_ts_pkg::ACT_ENTER;
      return key_beat(action, clock_byte(2), clock_byte(5), clock_byte(5));
   endfunction

   task automatic send_beat(input rtc_ts_pkg::req_payload_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      tracker.note_request(item);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // write the blink half period, then read it back
   task automatic program_blink_half(input logic [rtc_ts_pkg::HalfWidth-1:0] value);
      logic [rtc_ts_pkg::DataWidth-1:0] wide;
      wide = {{(rtc_ts_pkg::DataWidth - rtc_ts_pkg::HalfWidth){1'b0}}, value};
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {rtc_ts_pkg::REG_BLINK_HALF, 2'b00};
      csr_pwdata  <= wide;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      tracker.blink_half = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== wide) begin
         tracker.failures++;
         if (tracker.failures <= 10)
            $display("blink half readback: expected %h got %h", wide, csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_phase(input int unsigned count);
      repeat (count) send_beat(random_beat());
      drain();
   endtask

   initial begin
      tracker = new();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 37;
      recv_idle_pct = 58;
      program_blink_half(rtc_ts_pkg::BLINK_HALF_RESET);

      // actions on the zero values held since reset
      send_beat(key_beat(rtc_ts_pkg::ACT_TICK, 8'h00, 8'h00, 8'h00));
      send_beat(key_beat(rtc_ts_pkg::ACT_INCREMENT, 8'h00, 8'h00, 8'h00));
      send_beat(key_beat(rtc_ts_pkg::ACT_SELECT, 8'h00, 8'h00, 8'h00));
      send_beat(key_beat(rtc_ts_pkg::ACT_SAVE, 8'h00, 8'h00, 8'h00));
      // all-ones bytes load as zero
      send_beat(key_beat(rtc_ts_pkg::ACT_ENTER, 8'hFF, 8'hFF, 8'hFF));
      send_beat(key_beat(rtc_ts_pkg::ACT_CANCEL, 8'hFF, 8'hFF, 8'hFF));
      send_beat(key_beat(rtc_ts_pkg::ACT_ENTER, 8'h23, 8'h59, 8'h59));
      // second enter while loaded is ignored
      send_beat(key_beat(rtc_ts_pkg::ACT_ENTER, 8'h00, 8'h00, 8'h00));
      send_beat(key_beat(rtc_ts_pkg::ACT_INCREMENT, 8'h00, 8'h00, 8'h00));
      send_beat(key_beat(rtc_ts_pkg::ACT_SELECT, 8'h00, 8'h00, 8'h00));
      send_beat(key_beat(rtc_ts_pkg::ACT_INCREMENT, 8'h00, 8'h00, 8'h00));
      send_beat(key_beat(rtc_ts_pkg::ACT_SELECT, 8'h00, 8'h00, 8'h00));
      send_beat(key_beat(rtc_ts_pkg::ACT_INCREMENT, 8'h00, 8'h00, 8'h00));
      send_beat(key_beat(rtc_ts_pkg::ACT_SELECT, 8'h00, 8'h00, 8'h00));
      send_beat(key_beat(ACT_SPARE_LO, 8'hFF, 8'hFF, 8'hFF));
      send_beat(key_beat(ACT_SPARE_HI, 8'hFF, 8'hFF, 8'hFF));
      send_beat(key_beat(rtc_ts_pkg::ACT_SAVE, 8'h00, 8'h00, 8'h00));
      // masked tens digits and a minute of sixty
      send_beat(key_beat(rtc_ts_pkg::ACT_ENTER, 8'hA3, 8'h5A, 8'hD9));
      send_beat(key_beat(rtc_ts_pkg::ACT_SAVE, 8'h00, 8'h00, 8'h00));
      send_beat(key_beat(rtc_ts_pkg::ACT_ENTER, 8'h24, 8'h60, 8'h60));
      send_beat(key_beat(rtc_ts_pkg::ACT_CANCEL, 8'h00, 8'h00, 8'h00));
      send_beat(key_beat(rtc_ts_pkg::ACT_ENTER, 8'h19, 8'h3C, 8'h0F));
      send_beat(key_beat(rtc_ts_pkg::ACT_INCREMENT, 8'h00, 8'h00, 8'h00));
      send_beat(key_beat(rtc_ts_pkg::ACT_SAVE, 8'h00, 8'h00, 8'h00));
      drain();

      program_blink_half(15'd1);
      random_phase(130);

      send_idle_pct = 58;
      recv_idle_pct = 37;
      program_blink_half(15'd7);
      random_phase(130);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_blink_half(15'h7FFF);
      start_hold = 1'b1;
      random_phase(70);
      program_blink_half(15'd2);
      random_phase(70);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("[rtc_time_set_controller] OK");
      end else begin
         $display("[rtc_time_set_controller] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- rtc_time_set_controller.f -----
rtl/rtc_ts_pkg.sv
rtl/rtc_time_set_controller.sv
rtl/rtc_ts_checker.sv
dv/tb_rtc_time_set_controller.sv
